@@ hdl/form_url_byte_encoder_core_defines.svh @@
// assertion macros shared by the form url byte encoder checker
`ifndef FORM_URL_BYTE_ENCODER_CORE_DEFINES_SVH
`define FORM_URL_BYTE_ENCODER_CORE_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define FUBE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FUBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fube_pkg.sv @@
// types, character codes and encoding functions for the form url byte encoder
`default_nettype none
package fube_pkg;

  typedef enum logic [2:0] {
    K_PASS,
    K_PLUS,
    K_NL,
    K_HEX,
    K_MARK
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } entry_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // "%0D%0A"
  localparam logic [7:0] NL_SEQ [6] = '{8'h25, 8'h30, 8'h44, 8'h25, 8'h30, 8'h41};

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'h0, nib};
    if (nib < 4'd10) hex_char = 8'h30 + n8;
    else             hex_char = 8'h37 + n8;
  endfunction

  function automatic logic [2:0] run_len(input kind_t kind);
    case (kind)
      K_HEX:   run_len = 3'd3;
      K_NL:    run_len = 3'd6;
      default: run_len = 3'd1;
    endcase
  endfunction

  function automatic logic [7:0] enc_char(input entry_t e, input logic [2:0] idx);
    case (e.kind)
      K_PASS: enc_char = e.data;
      K_PLUS: enc_char = CH_PLUS;
      K_NL:   enc_char = (idx < 3'd6) ? NL_SEQ[idx] : CH_NUL;
      K_HEX: begin
        if (idx == 3'd0)      enc_char = CH_PCT;
        else if (idx == 3'd1) enc_char = hex_char(e.data[7:4]);
        else                  enc_char = hex_char(e.data[3:0]);
      end
      default: enc_char = CH_NUL;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/fube_front.sv @@
// front stage: accepts raw bytes and classifies them into queue entries
`default_nettype none
module fube_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output fube_pkg::entry_t     push_entry
);
  import fube_pkg::*;

  logic   ent_v_r, ent_v_nxt;
  entry_t ent_r;
  kind_t  kind;
  logic   is_cr;
  logic   accept;

  function automatic logic is_passed(input logic [7:0] c);
    is_passed = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
                (c >= 8'h30 && c <= 8'h39) ||
                c == 8'h24 || c == 8'h2D || c == 8'h2E || c == 8'h5F ||
                c == 8'h21 || c == 8'h2A || c == 8'h28 || c == 8'h29 ||
                c == 8'h2C;
  endfunction

  always_comb begin
    is_cr = (in_byte == CH_CR);
    if (is_passed(in_byte))        kind = K_PASS;
    else if (in_byte == CH_SPACE)  kind = K_PLUS;
    else if (in_byte == CH_LF)     kind = K_NL;
    else if (is_cr)                kind = K_MARK;
    else                           kind = K_HEX;
  end

  assign in_ready   = !ent_v_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = ent_v_r;
  assign push_entry = ent_r;

  // a dropped carriage return only leaves an entry when it ends the string
  always_comb begin
    if (accept)                     ent_v_nxt = !(is_cr && !in_last);
    else if (ent_v_r && push_ready) ent_v_nxt = 1'b0;
    else                            ent_v_nxt = ent_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r <= 1'b0;
    end else begin
      ent_v_r <= ent_v_nxt;
    end
    if (accept) begin
      ent_r.kind <= kind;
      ent_r.data <= in_byte;
      ent_r.last <= in_last;
    end
  end

endmodule
`default_nettype wire

@@ hdl/fube_queue.sv @@
// small register queue between the classifier and the output sequencer
`default_nettype none
module fube_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire fube_pkg::entry_t push_entry,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output fube_pkg::entry_t     pop_entry
);
  import fube_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) mem_r[wr_ptr_r] <= push_entry;
  end

endmodule
`default_nettype wire

@@ hdl/fube_back.sv @@
// back stage: expands one entry into its run of encoded bytes, one per cycle while the output is not stalled
`default_nettype none
module fube_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire fube_pkg::entry_t pop_entry,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_has_byte,
  output logic                  out_run_last,
  output logic                  out_string_end
);
  import fube_pkg::*;

  entry_t     cur_r;
  logic       cur_v_r, cur_v_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       o_v_r, o_v_nxt;
  logic [7:0] o_byte_r;
  logic       o_has_r, o_run_r, o_end_r;
  logic       adv, emit, fin;

  assign adv       = !o_v_r || out_ready;
  assign emit      = cur_v_r && adv;
  assign fin       = (idx_r == run_len(cur_r.kind) - 3'd1);
  // next entry loads as the current one hands out its final byte
  assign pop_ready = !cur_v_r || (emit && fin);

  always_comb begin
    cur_v_nxt = cur_v_r;
    idx_nxt   = idx_r;
    if (pop_valid && pop_ready) begin
      cur_v_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (emit && fin) begin
      cur_v_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 3'd1;
    end
    if (emit)           o_v_nxt = 1'b1;
    else if (out_ready) o_v_nxt = 1'b0;
    else                o_v_nxt = o_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= '0;
      o_v_r   <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      idx_r   <= idx_nxt;
      o_v_r   <= o_v_nxt;
    end
    if (pop_valid && pop_ready) cur_r <= pop_entry;
    if (emit) begin
      o_byte_r <= enc_char(cur_r, idx_r);
      o_has_r  <= (cur_r.kind != K_MARK);
      o_run_r  <= fin;
      o_end_r  <= fin && cur_r.last;
    end
  end

  assign out_valid      = o_v_r;
  assign out_byte       = o_byte_r;
  assign out_has_byte   = o_has_r;
  assign out_run_last   = o_run_r;
  assign out_string_end = o_end_r;

endmodule
`default_nettype wire

@@ hdl/form_url_byte_encoder_core.sv @@
// top level of the form url byte encoder
//
//  channel | ports                                            | direction
//  input   | in_valid in_ready in_byte in_last                | into block
//  result  | out_valid out_ready out_byte out_has_byte        | out of block
//          | out_run_last out_string_end                      |
//
// results leave at one byte per cycle from the output sequencer while it is
// not stalled; an item yields one result (passed byte, space, end marker),
// three (escaped byte) or six (line feed); a dropped carriage return that
// does not end the string yields none. items pass the classifier register,
// the queue and the sequencer. synchronous reset clears all valid flags; the
// queue lets the classifier keep taking items while the output is stalled.
`default_nettype none
module form_url_byte_encoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_run_last,
  output logic            out_string_end
);
  import fube_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  fube_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  fube_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  fube_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_entry      (pop_entry),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_has_byte   (out_has_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end)
  );

endmodule
`default_nettype wire

@@ hdl/fube_checker.sv @@
// port-level checks for the form url byte encoder, bound to the top level
`default_nettype none
`include "form_url_byte_encoder_core_defines.svh"
module fube_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_has_byte,
  input wire logic       out_run_last,
  input wire logic       out_string_end
);
  import fube_pkg::*;

  // an end marker carries no byte and closes both the run and the string
  `FUBE_ASSERT_ALWAYS(a_marker_shape, !out_valid || out_has_byte || (out_byte == CH_NUL && out_run_last && out_string_end), "bad end marker")
  `FUBE_ASSERT_ALWAYS(a_end_closes_run, !out_valid || !out_string_end || out_run_last, "string end without run end")
  // a percent sign always opens an escape, never ends a run
  `FUBE_ASSERT_ALWAYS(a_pct_not_last, !(out_valid && out_has_byte && out_byte == CH_PCT) || !out_run_last, "percent ends a run")
  `FUBE_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_run_last), "result changed while stalled")

endmodule

bind form_url_byte_encoder_core fube_checker u_fube_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_has_byte   (out_has_byte),
  .out_run_last   (out_run_last),
  .out_string_end (out_string_end)
);
`default_nettype wire
